// ===== design/i2c_master_status_sequencer_top_defines.svh =====
// assertion helpers shared by the checker
`ifndef I2C_MASTER_STATUS_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_STATUS_SEQUENCER_TOP_DEFINES_SVH

// condition holds in the same cycle
`define I2CMS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("i2cms check failed");

// condition holds in the next cycle
`define I2CMS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("i2cms check failed");

`endif

// ===== design/i2cms_pkg.sv =====
package i2cms_pkg;

  localparam int BUF_SIZE_DEF = 32;

  localparam int POS_W   = 6;
  localparam int CNT_W   = 5;
  localparam int PHASE_W = 3;
  localparam int BYTE_W  = 8;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_EVENT = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic REG_WRITE_COUNT = 1'b0;
  localparam logic REG_READ_COUNT  = 1'b1;

  localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STARTED      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RESTARTED    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RSTART_ASKED = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA_ACK     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE         = 3'd5;

  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_WADDR_ACK   = 8'h18;
  localparam logic [7:0] ST_WADDR_NACK  = 8'h20;
  localparam logic [7:0] ST_WDATA_ACK   = 8'h28;
  localparam logic [7:0] ST_WDATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_RADDR_ACK   = 8'h40;
  localparam logic [7:0] ST_RADDR_NACK  = 8'h48;
  localparam logic [7:0] ST_RDATA_ACK   = 8'h50;
  localparam logic [7:0] ST_RDATA_NACK  = 8'h58;

endpackage

// ===== design/i2cms_ram.sv =====
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/i2c_master_status_sequencer_top.sv =====
// results are registered; a result beat is valid in the cycle after its input beat is accepted
// throughput: one item per cycle while results are taken; a stalled result holds the input side only
//   until it is taken, the buffer read port is registered in the same stage
// reset: clears positions, phase, both count registers and the per-entry
//   buffer valid bits at once; an entry never written reads as zero
module i2c_master_status_sequencer_top
  import i2cms_pkg::*;
#(
  parameter int BUF_SIZE = BUF_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_en,
  input  logic               cfg_index,
  input  logic [CNT_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [4:0]         buffer_index,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [7:0]         status_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               send_valid,
  output logic [BYTE_W-1:0]  send_byte,
  output logic               start_request,
  output logic               stop_request,
  output logic               start_clear,
  output logic               ack_assert,
  output logic               ack_clear,
  output logic [PHASE_W-1:0] master_phase,
  output logic               transfer_done,
  output logic [BYTE_W-1:0]  read_byte
);

  localparam int AW = $clog2(BUF_SIZE);
  localparam int CW = ((AW > POS_W + 1) ? AW : POS_W + 1) + 1;

  logic [CNT_W-1:0]   write_count;
  logic [CNT_W-1:0]   read_count;
  logic [POS_W-1:0]   write_position, write_position_next;
  logic [POS_W-1:0]   read_position, read_position_next;
  logic [POS_W-1:0]   rp_inc;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [BUF_SIZE-1:0] filled;

  logic accept;
  logic rd_en, wr_en, rd_in, wr_in, ram_re, ram_we;
  logic [CW-1:0] rd_full, wr_full;
  logic [BYTE_W-1:0] ram_rdata;

  logic send_next, start_req_next, stop_req_next, start_clr_next;
  logic ack_set_next, ack_clr_next, sel_read_next;
  logic sel_read, rd_ok;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      read_count  <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_WRITE_COUNT: write_count <= cfg_data;
        REG_READ_COUNT:  read_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode of one beat
  always_comb begin
    write_position_next = write_position;
    read_position_next  = read_position;
    phase_next          = phase;
    rp_inc              = read_position + POS_W'(1);
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    rd_full        = '0;
    wr_full        = '0;
    send_next      = 1'b0;
    start_req_next = 1'b0;
    stop_req_next  = 1'b0;
    start_clr_next = 1'b0;
    ack_set_next   = 1'b0;
    ack_clr_next   = 1'b0;
    sel_read_next  = 1'b0;
    unique case (mode)
      MODE_START: begin
        write_position_next = '0;
        read_position_next  = '0;
        phase_next          = PH_IDLE;
      end
      MODE_LOAD: begin
        wr_en   = 1'b1;
        wr_full = CW'(buffer_index);
      end
      MODE_READ: begin
        rd_en         = 1'b1;
        rd_full       = CW'(buffer_index);
        sel_read_next = 1'b1;
      end
      MODE_EVENT: begin
        unique case (status_code)
          ST_START: begin
            send_next      = 1'b1;
            rd_en          = 1'b1;
            rd_full        = CW'(0);
            start_clr_next = 1'b1;
            phase_next     = PH_STARTED;
          end
          ST_RSTART: begin
            send_next      = 1'b1;
            rd_en          = 1'b1;
            rd_full        = CW'(2);
            start_clr_next = 1'b1;
            phase_next     = PH_RESTARTED;
          end
          ST_WADDR_ACK: begin
            if (phase == PH_STARTED) begin
              send_next           = 1'b1;
              rd_en               = 1'b1;
              rd_full             = CW'(write_position) + CW'(1);
              write_position_next = write_position + POS_W'(1);
              phase_next          = PH_DATA_ACK;
            end
          end
          ST_WDATA_ACK, ST_WDATA_NACK: begin
            if (write_position != POS_W'(write_count)) begin
              send_next           = 1'b1;
              rd_en               = 1'b1;
              rd_full             = CW'(write_position) + CW'(1);
              write_position_next = write_position + POS_W'(1);
              phase_next          = PH_DATA_ACK;
            end else if (read_count != '0) begin
              start_req_next = 1'b1;
              phase_next     = PH_RSTART_ASKED;
            end else begin
              stop_req_next = 1'b1;
              phase_next    = PH_DONE;
            end
          end
          ST_RADDR_ACK: begin
            ack_set_next = (read_count >= CNT_W'(2));
          end
          ST_RDATA_ACK, ST_RDATA_NACK: begin
            wr_en              = 1'b1;
            wr_full            = CW'(read_position) + CW'(3);
            read_position_next = rp_inc;
            if (read_count == '0 ||
                (CW'(rp_inc) + CW'(1)) < CW'(read_count)) begin
              phase_next   = PH_DATA_ACK;
              ack_set_next = 1'b1;
            end else begin
              ack_clr_next = 1'b1;
            end
            if (rp_inc == POS_W'(read_count)) begin
              read_position_next = '0;
              phase_next         = PH_DONE;
            end
          end
          ST_WADDR_NACK, ST_RADDR_NACK: begin
            phase_next = PH_DONE;
          end
          ST_ARB_LOST: ;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign rd_in  = rd_full < CW'(BUF_SIZE);
  assign wr_in  = wr_full < CW'(BUF_SIZE);
  assign ram_re = accept && rd_en && rd_in;
  assign ram_we = accept && wr_en && wr_in;

  i2cms_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_SIZE)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_full[AW-1:0]),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (rd_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer state and buffer valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      read_position  <= '0;
      phase          <= PH_IDLE;
      filled         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        write_position <= write_position_next;
        read_position  <= read_position_next;
        phase          <= phase_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        filled[wr_full[AW-1:0]] <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      send_valid    <= send_next;
      start_request <= start_req_next;
      stop_request  <= stop_req_next;
      start_clear   <= start_clr_next;
      ack_assert    <= ack_set_next;
      ack_clear     <= ack_clr_next;
      sel_read      <= sel_read_next;
      rd_ok         <= rd_en && rd_in && filled[rd_full[AW-1:0]];
    end
  end

  assign send_byte     = (send_valid && rd_ok) ? ram_rdata : '0;
  assign read_byte     = (sel_read && rd_ok) ? ram_rdata : '0;
  assign master_phase  = phase;
  assign transfer_done = (phase == PH_DONE);

endmodule

// ===== design/i2cms_checker.sv =====
`include "i2c_master_status_sequencer_top_defines.svh"

module i2cms_checker
  import i2cms_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               send_valid,
  input logic [BYTE_W-1:0]  send_byte,
  input logic               start_request,
  input logic               stop_request,
  input logic               ack_assert,
  input logic               ack_clear,
  input logic [PHASE_W-1:0] master_phase,
  input logic               transfer_done,
  input logic [BYTE_W-1:0]  read_byte
);

  // done flag follows the reported phase
  `I2CMS_ASSERT_NOW(a_done_phase, out_valid, transfer_done == (master_phase == PH_DONE))

  // no byte shown without its send flag
  `I2CMS_ASSERT_NOW(a_send_zero, out_valid && !send_valid, send_byte == '0)

  // a status beat never returns buffer read data
  `I2CMS_ASSERT_NOW(a_read_excl, out_valid && send_valid, read_byte == '0)

  // a status beat raises at most one bus action
  `I2CMS_ASSERT_NOW(a_one_action, out_valid, $countones({send_valid, start_request, stop_request,
                                                         ack_assert, ack_clear}) <= 1)

  // a stalled result beat stays
  `I2CMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind i2c_master_status_sequencer_top i2cms_checker u_i2cms_checker (.*);
